FILE: sv/coulomb_force_sum_unit_macros.svh
// ----------------------------------------------------------------------------
// Coulomb force sum unit assertion macros
// Short forms for the port checker's concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef COULOMB_FORCE_SUM_UNIT_MACROS_SVH
`define COULOMB_FORCE_SUM_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define CFSU_CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define CFSU_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/cfsu_pkg.sv
// ----------------------------------------------------------------------------
// Coulomb force sum unit package
// Widths, constants, sequencer states and controller/datapath interface types.
// ----------------------------------------------------------------------------
package cfsu_pkg;

    // Field and internal widths
    localparam int POS_W   = 32;          // Q8.24 position
    localparam int DIFF_W  = 33;          // exact position difference
    localparam int MAG_W   = 32;          // |d| >> 1, Q9.23
    localparam int CHG_W   = 16;          // Q4.12 charge
    localparam int Q_W     = 32;          // charge product, Q8.24
    localparam int QMAG_W  = 31;          // |qt*qs| <= 2^30
    localparam int R2_W    = 64;          // squared distance
    localparam int ROOT_W  = 32;          // floor(sqrt(r2))
    localparam int SQR_W   = 34;          // square root partial remainder
    localparam int MUL_W   = 32;          // shared multiplier operand
    localparam int PROD_W  = 64;          // shared multiplier product
    localparam int DEN_W   = 96;          // r2 * r
    localparam int A_W     = 63;          // |q| * m
    localparam int QUO_W   = 47;          // term quotient bits
    localparam int NUM_SH  = 38;          // numerator scale 2^38
    localparam int OVF_SH  = QUO_W - NUM_SH;
    localparam int FRC_W   = 48;          // sums and forces
    localparam int SUMX_W  = FRC_W + 2;   // sum plus term before clamping
    localparam int SP_W    = 78;          // |sum| * scale
    localparam int RND_SH  = 24;          // scale fraction bits
    localparam int RR_W    = SP_W - RND_SH;

    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = QUO_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    // 41.84 in Q.24
    localparam logic [29:0] SCALE_Q24 = 30'd701958717;

    localparam logic [FRC_W-1:0] SUM_MAX = {1'b0, {(FRC_W-1){1'b1}}};
    localparam logic [FRC_W-1:0] SUM_MIN = {1'b1, {(FRC_W-1){1'b0}}};

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SQ,
        ST_SQW,
        ST_DEC,
        ST_SQRT,
        ST_MUL,
        ST_MULW,
        ST_DINIT,
        ST_DIV,
        ST_ACC,
        ST_SCL,
        ST_SCLW,
        ST_EMIT
    } t_state;

    // Shared multiplier operations; the tag travels with the product
    typedef enum logic [3:0] {
        MOP_NONE,
        MOP_SQ_X,
        MOP_SQ_Y,
        MOP_SQ_Z,
        MOP_DEN_LO,
        MOP_DEN_HI,
        MOP_NUM_X,
        MOP_NUM_Y,
        MOP_NUM_Z,
        MOP_SCL_LO_X,
        MOP_SCL_HI_X,
        MOP_SCL_LO_Y,
        MOP_SCL_HI_Y,
        MOP_SCL_LO_Z,
        MOP_SCL_HI_Z
    } t_mop;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture an input word
        logic prep;        // magnitudes, clear r2
        t_mop mop;         // multiplier issue
        logic sqrt_init;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic acc;         // add the three terms into the sums
        logic zflag_set;   // coincident source seen
        logic emit;        // load output register, clear sums
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic r2_zero;
        logic q_zero;
        logic last;
        logic out_busy;
    } t_stat;

endpackage

FILE: sv/cfsu_datapath.sv
// ----------------------------------------------------------------------------
// Coulomb force sum datapath
// Shared 32x32 multiplier, bit-serial square root, three division lanes,
// saturating accumulators and the output scaling and register.
// ----------------------------------------------------------------------------
module cfsu_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  cfsu_pkg::t_cmd                       i_cmd,
    output cfsu_pkg::t_stat                      o_stat,
    input  logic signed [cfsu_pkg::POS_W-1:0]    i_target_x,
    input  logic signed [cfsu_pkg::POS_W-1:0]    i_target_y,
    input  logic signed [cfsu_pkg::POS_W-1:0]    i_target_z,
    input  logic signed [cfsu_pkg::CHG_W-1:0]    i_target_charge,
    input  logic signed [cfsu_pkg::POS_W-1:0]    i_source_x,
    input  logic signed [cfsu_pkg::POS_W-1:0]    i_source_y,
    input  logic signed [cfsu_pkg::POS_W-1:0]    i_source_z,
    input  logic signed [cfsu_pkg::CHG_W-1:0]    i_source_charge,
    input  logic                                 i_last_source,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [cfsu_pkg::FRC_W-1:0]    o_force_x,
    output logic signed [cfsu_pkg::FRC_W-1:0]    o_force_y,
    output logic signed [cfsu_pkg::FRC_W-1:0]    o_force_z,
    output logic                                 o_coincident_seen,
    output logic                                 o_saturated
);
    import cfsu_pkg::*;

    // Input views per axis
    logic signed [POS_W-1:0] tgt [3];
    logic signed [POS_W-1:0] src [3];

    // Per item registers
    logic [DIFF_W-1:0]  r_d [3];
    logic [DIFF_W-1:0]  d_abs [3];
    logic [MAG_W-1:0]   r_m [3];
    logic signed [Q_W-1:0] r_q;
    logic [Q_W-1:0]     q_abs;
    logic [QMAG_W-1:0]  r_qmag;
    logic               r_qneg;
    logic               r_last;
    logic [R2_W-1:0]    r_r2;

    // Shared multiplier
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [PROD_W-1:0]  r_prod;
    t_mop               r_mop;

    // Square root
    logic [R2_W-1:0]    r_sq_v;
    logic [SQR_W-1:0]   r_sq_rem;
    logic [ROOT_W-1:0]  r_root;
    logic [SQR_W+1:0]   sq_sh;
    logic [SQR_W+1:0]   sq_trial;
    logic               sq_ge;

    // Division lanes
    logic [DEN_W-1:0]   r_den;
    logic [A_W-1:0]     r_a [3];
    logic [DEN_W-1:0]   r_rem [3];
    logic [QUO_W-1:0]   r_nb [3];
    logic [QUO_W-1:0]   r_quo [3];
    logic               r_ovf [3];
    logic [DEN_W:0]     dv_sh [3];
    logic               dv_ge [3];
    logic               ovf_chk [3];

    // Accumulators
    logic [FRC_W-1:0]   r_sum [3];
    logic               r_zflag;
    logic               r_oflag;
    logic [FRC_W-1:0]   term_mag [3];
    logic signed [SUMX_W-1:0] term [3];
    logic signed [SUMX_W-1:0] sum_new [3];
    logic [FRC_W-1:0]   sum_clip [3];
    logic               sum_ovf [3];
    logic               acc_flag;

    // Output scaling
    logic [FRC_W-1:0]   smag [3];
    logic [SP_W-1:0]    r_sp [3];
    logic [SP_W-1:0]    sp_rnd [3];
    logic [RR_W-1:0]    rr [3];
    logic [FRC_W-1:0]   scl_out [3];
    logic               scl_sat [3];
    logic               emit_sat;
    logic               r_oval;
    logic [FRC_W-1:0]   r_of [3];
    logic               r_ocs;
    logic               r_osat;

    assign tgt[0] = i_target_x;
    assign tgt[1] = i_target_y;
    assign tgt[2] = i_target_z;
    assign src[0] = i_source_x;
    assign src[1] = i_source_y;
    assign src[2] = i_source_z;

    // Magnitudes of the registered difference and charge product
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d_abs[k] = r_d[k][DIFF_W-1] ? (~r_d[k] + 1'b1) : r_d[k];
        end
        q_abs = r_q[Q_W-1] ? (~r_q + 1'b1) : r_q;
    end

    // Sum magnitudes for scaling
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            smag[k] = r_sum[k][FRC_W-1] ? (~r_sum[k] + 1'b1) : r_sum[k];
        end
    end

    // Multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mop)
            MOP_SQ_X: begin
                mul_a = r_m[0];
                mul_b = r_m[0];
            end
            MOP_SQ_Y: begin
                mul_a = r_m[1];
                mul_b = r_m[1];
            end
            MOP_SQ_Z: begin
                mul_a = r_m[2];
                mul_b = r_m[2];
            end
            MOP_DEN_LO: begin
                mul_a = r_r2[MUL_W-1:0];
                mul_b = r_root;
            end
            MOP_DEN_HI: begin
                mul_a = r_r2[R2_W-1:MUL_W];
                mul_b = r_root;
            end
            MOP_NUM_X: begin
                mul_a = MUL_W'(r_qmag);
                mul_b = r_m[0];
            end
            MOP_NUM_Y: begin
                mul_a = MUL_W'(r_qmag);
                mul_b = r_m[1];
            end
            MOP_NUM_Z: begin
                mul_a = MUL_W'(r_qmag);
                mul_b = r_m[2];
            end
            MOP_SCL_LO_X: begin
                mul_a = smag[0][MUL_W-1:0];
                mul_b = MUL_W'(SCALE_Q24);
            end
            MOP_SCL_HI_X: begin
                mul_a = MUL_W'(smag[0][FRC_W-1:MUL_W]);
                mul_b = MUL_W'(SCALE_Q24);
            end
            MOP_SCL_LO_Y: begin
                mul_a = smag[1][MUL_W-1:0];
                mul_b = MUL_W'(SCALE_Q24);
            end
            MOP_SCL_HI_Y: begin
                mul_a = MUL_W'(smag[1][FRC_W-1:MUL_W]);
                mul_b = MUL_W'(SCALE_Q24);
            end
            MOP_SCL_LO_Z: begin
                mul_a = smag[2][MUL_W-1:0];
                mul_b = MUL_W'(SCALE_Q24);
            end
            MOP_SCL_HI_Z: begin
                mul_a = MUL_W'(smag[2][FRC_W-1:MUL_W]);
                mul_b = MUL_W'(SCALE_Q24);
            end
            default: ;
        endcase
    end

    // Square root step: bring down two bits, trial subtract
    assign sq_sh    = {r_sq_rem, r_sq_v[R2_W-1 -: 2]};
    assign sq_trial = (SQR_W+2)'({r_root, 2'b01});
    assign sq_ge    = (sq_sh >= sq_trial);

    // Division lanes: restoring step and quotient overflow check
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dv_sh[k]   = {r_rem[k], r_nb[k][QUO_W-1]};
            dv_ge[k]   = (dv_sh[k] >= {1'b0, r_den});
            ovf_chk[k] = ((DEN_W+OVF_SH)'(r_a[k]) >= {r_den, {OVF_SH{1'b0}}});
        end
    end

    // Signed terms, saturating add
    always_comb begin
        acc_flag = 1'b0;
        for (int k = 0; k < 3; k++) begin
            term_mag[k] = r_ovf[k] ? SUM_MIN : FRC_W'(r_quo[k]);
            term[k]     = (r_qneg ^ r_d[k][DIFF_W-1])
                          ? -$signed(SUMX_W'(term_mag[k]))
                          :  $signed(SUMX_W'(term_mag[k]));
            sum_new[k]  = $signed({{2{r_sum[k][FRC_W-1]}}, r_sum[k]}) + term[k];
            sum_ovf[k]  = !((sum_new[k][SUMX_W-1:FRC_W-1] == 3'b000) ||
                            (sum_new[k][SUMX_W-1:FRC_W-1] == 3'b111));
            if (sum_ovf[k]) begin
                sum_clip[k] = sum_new[k][SUMX_W-1] ? SUM_MIN : SUM_MAX;
            end else begin
                sum_clip[k] = sum_new[k][FRC_W-1:0];
            end
            acc_flag = acc_flag | sum_ovf[k] | r_ovf[k];
        end
    end

    // Output scaling: round half up on the magnitude, clamp, restore sign
    always_comb begin
        emit_sat = 1'b0;
        for (int k = 0; k < 3; k++) begin
            sp_rnd[k] = r_sp[k] + SP_W'(1 << (RND_SH - 1));
            rr[k]     = sp_rnd[k][SP_W-1:RND_SH];
            if (r_sum[k][FRC_W-1]) begin
                scl_sat[k] = (rr[k] > RR_W'(SUM_MIN));
                scl_out[k] = scl_sat[k] ? SUM_MIN : (~rr[k][FRC_W-1:0] + 1'b1);
            end else begin
                scl_sat[k] = (rr[k] > RR_W'(SUM_MAX));
                scl_out[k] = scl_sat[k] ? SUM_MAX : rr[k][FRC_W-1:0];
            end
            emit_sat = emit_sat | scl_sat[k];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        // product consumption, in the cycle after issue
        case (r_mop)
            MOP_SQ_X, MOP_SQ_Y, MOP_SQ_Z: r_r2 <= r_r2 + r_prod;
            MOP_DEN_LO:   r_den   <= DEN_W'(r_prod);
            MOP_DEN_HI:   r_den   <= r_den + {r_prod, {MUL_W{1'b0}}};
            MOP_NUM_X:    r_a[0]  <= r_prod[A_W-1:0];
            MOP_NUM_Y:    r_a[1]  <= r_prod[A_W-1:0];
            MOP_NUM_Z:    r_a[2]  <= r_prod[A_W-1:0];
            MOP_SCL_LO_X: r_sp[0] <= SP_W'(r_prod);
            MOP_SCL_HI_X: r_sp[0] <= r_sp[0] + {r_prod[SP_W-MUL_W-1:0], {MUL_W{1'b0}}};
            MOP_SCL_LO_Y: r_sp[1] <= SP_W'(r_prod);
            MOP_SCL_HI_Y: r_sp[1] <= r_sp[1] + {r_prod[SP_W-MUL_W-1:0], {MUL_W{1'b0}}};
            MOP_SCL_LO_Z: r_sp[2] <= SP_W'(r_prod);
            MOP_SCL_HI_Z: r_sp[2] <= r_sp[2] + {r_prod[SP_W-MUL_W-1:0], {MUL_W{1'b0}}};
            default: ;
        endcase

        r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);

        // input word capture
        if (i_cmd.load) begin
            for (int k = 0; k < 3; k++) begin
                r_d[k] <= {tgt[k][POS_W-1], tgt[k]} - {src[k][POS_W-1], src[k]};
            end
            r_q    <= Q_W'(i_target_charge) * Q_W'(i_source_charge);
            r_last <= i_last_source;
        end

        if (i_cmd.prep) begin
            for (int k = 0; k < 3; k++) begin
                r_m[k] <= d_abs[k][DIFF_W-1:1];
            end
            r_qmag <= q_abs[QMAG_W-1:0];
            r_qneg <= r_q[Q_W-1];
            r_r2   <= '0;
        end

        // square root
        if (i_cmd.sqrt_init) begin
            r_sq_v   <= r_r2;
            r_sq_rem <= '0;
            r_root   <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_sq_v <= {r_sq_v[R2_W-3:0], 2'b00};
            if (sq_ge) begin
                r_sq_rem <= SQR_W'(sq_sh - sq_trial);
                r_root   <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_sq_rem <= sq_sh[SQR_W-1:0];
                r_root   <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end

        // division lanes
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.div_init) begin
                r_ovf[k] <= ovf_chk[k];
                r_rem[k] <= DEN_W'(r_a[k][A_W-1:OVF_SH]);
                r_nb[k]  <= {r_a[k][OVF_SH-1:0], {NUM_SH{1'b0}}};
                r_quo[k] <= '0;
            end else if (i_cmd.div_step) begin
                r_nb[k] <= {r_nb[k][QUO_W-2:0], 1'b0};
                if (dv_ge[k]) begin
                    r_rem[k] <= DEN_W'(dv_sh[k] - {1'b0, r_den});
                    r_quo[k] <= {r_quo[k][QUO_W-2:0], 1'b1};
                end else begin
                    r_rem[k] <= dv_sh[k][DEN_W-1:0];
                    r_quo[k] <= {r_quo[k][QUO_W-2:0], 1'b0};
                end
            end
        end

        // output word
        if (i_cmd.emit) begin
            for (int k = 0; k < 3; k++) begin
                r_of[k] <= scl_out[k];
            end
            r_ocs  <= r_zflag;
            r_osat <= r_oflag | emit_sat;
        end
    end

    // Control and accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mop   <= MOP_NONE;
            r_zflag <= 1'b0;
            r_oflag <= 1'b0;
            r_oval  <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_sum[k] <= '0;
            end
        end else begin
            r_mop <= i_cmd.mop;
            if (i_cmd.emit) begin
                r_zflag <= 1'b0;
                r_oflag <= 1'b0;
                for (int k = 0; k < 3; k++) begin
                    r_sum[k] <= '0;
                end
            end else begin
                if (i_cmd.zflag_set) begin
                    r_zflag <= 1'b1;
                end
                if (i_cmd.acc) begin
                    r_oflag <= r_oflag | acc_flag;
                    for (int k = 0; k < 3; k++) begin
                        r_sum[k] <= sum_clip[k];
                    end
                end
            end
            if (i_cmd.emit) begin
                r_oval <= 1'b1;
            end else if (i_out_ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    // Status
    assign o_stat.r2_zero  = (r_r2 == '0);
    assign o_stat.q_zero   = (r_q == '0);
    assign o_stat.last     = r_last;
    assign o_stat.out_busy = r_oval & ~i_out_ready;

    assign o_out_valid       = r_oval;
    assign o_force_x         = r_of[0];
    assign o_force_y         = r_of[1];
    assign o_force_z         = r_of[2];
    assign o_coincident_seen = r_ocs;
    assign o_saturated       = r_osat;

endmodule

FILE: sv/cfsu_ctrl.sv
// ----------------------------------------------------------------------------
// Coulomb force sum controller
// Sequences capture, squares, square root, products, division, accumulation
// and output scaling for one input word at a time.
// ----------------------------------------------------------------------------
module cfsu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output cfsu_pkg::t_cmd  o_cmd,
    input  cfsu_pkg::t_stat i_stat
);
    import cfsu_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    // State and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_cnt      = '0;
        o_cmd      = '0;
        o_cmd.mop  = MOP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_SQ;
            end
            // squared half-distances, one axis a cycle
            ST_SQ: begin
                case (r_cnt)
                    CNT_W'(0): o_cmd.mop = MOP_SQ_X;
                    CNT_W'(1): o_cmd.mop = MOP_SQ_Y;
                    default:   o_cmd.mop = MOP_SQ_Z;
                endcase
                if (r_cnt == CNT_W'(2)) begin
                    n_state = ST_SQW;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_SQW: n_state = ST_DEC;
            // skip coincident or uncharged sources
            ST_DEC: begin
                if (i_stat.r2_zero || i_stat.q_zero) begin
                    o_cmd.zflag_set = i_stat.r2_zero;
                    n_state = i_stat.last ? ST_SCL : ST_IDLE;
                end else begin
                    o_cmd.sqrt_init = 1'b1;
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_state = ST_MUL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            // denominator halves, then the three numerators
            ST_MUL: begin
                case (r_cnt)
                    CNT_W'(0): o_cmd.mop = MOP_DEN_LO;
                    CNT_W'(1): o_cmd.mop = MOP_DEN_HI;
                    CNT_W'(2): o_cmd.mop = MOP_NUM_X;
                    CNT_W'(3): o_cmd.mop = MOP_NUM_Y;
                    default:   o_cmd.mop = MOP_NUM_Z;
                endcase
                if (r_cnt == CNT_W'(4)) begin
                    n_state = ST_MULW;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_MULW: n_state = ST_DINIT;
            ST_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_ACC;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = i_stat.last ? ST_SCL : ST_IDLE;
            end
            // sum magnitudes times 41.84, low and high part per axis
            ST_SCL: begin
                case (r_cnt)
                    CNT_W'(0): o_cmd.mop = MOP_SCL_LO_X;
                    CNT_W'(1): o_cmd.mop = MOP_SCL_HI_X;
                    CNT_W'(2): o_cmd.mop = MOP_SCL_LO_Y;
                    CNT_W'(3): o_cmd.mop = MOP_SCL_HI_Y;
                    CNT_W'(4): o_cmd.mop = MOP_SCL_LO_Z;
                    default:   o_cmd.mop = MOP_SCL_HI_Z;
                endcase
                if (r_cnt == CNT_W'(5)) begin
                    n_state = ST_SCLW;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_SCLW: n_state = ST_EMIT;
            // wait for the output register to free up
            ST_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

FILE: sv/coulomb_force_sum_unit.sv
// A source at nonzero distance with nonzero charge passes a 32-step square root and
// 47-step division lanes (three, sharing one divisor) before the next accept; a
// coincident or uncharged source skips both. A last source adds scaling on the
// shared 32x32 multiplier; its result word is valid once the output register is free,
// then holds. Reset (synchronous, active low) clears the sums, the flags and the
// output valid.
// ----------------------------------------------------------------------------
// Coulomb force sum unit
// Accumulates qt*qs*r/|r|^3 over a stream of sources and emits the sum
// scaled by 41.84 on the last source.
// ----------------------------------------------------------------------------
module coulomb_force_sum_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [cfsu_pkg::POS_W-1:0]    i_target_x,
    input  logic signed [cfsu_pkg::POS_W-1:0]    i_target_y,
    input  logic signed [cfsu_pkg::POS_W-1:0]    i_target_z,
    input  logic signed [cfsu_pkg::CHG_W-1:0]    i_target_charge,
    input  logic signed [cfsu_pkg::POS_W-1:0]    i_source_x,
    input  logic signed [cfsu_pkg::POS_W-1:0]    i_source_y,
    input  logic signed [cfsu_pkg::POS_W-1:0]    i_source_z,
    input  logic signed [cfsu_pkg::CHG_W-1:0]    i_source_charge,
    input  logic                                 i_last_source,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [cfsu_pkg::FRC_W-1:0]    o_force_x,
    output logic signed [cfsu_pkg::FRC_W-1:0]    o_force_y,
    output logic signed [cfsu_pkg::FRC_W-1:0]    o_force_z,
    output logic                                 o_coincident_seen,
    output logic                                 o_saturated
);
    import cfsu_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer
    cfsu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // Arithmetic and output register
    cfsu_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_target_x        (i_target_x),
        .i_target_y        (i_target_y),
        .i_target_z        (i_target_z),
        .i_target_charge   (i_target_charge),
        .i_source_x        (i_source_x),
        .i_source_y        (i_source_y),
        .i_source_z        (i_source_z),
        .i_source_charge   (i_source_charge),
        .i_last_source     (i_last_source),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_force_x         (o_force_x),
        .o_force_y         (o_force_y),
        .o_force_z         (o_force_z),
        .o_coincident_seen (o_coincident_seen),
        .o_saturated       (o_saturated)
    );

endmodule

FILE: sv/cfsu_checker.sv
// ----------------------------------------------------------------------------
// Coulomb force sum unit port checker
// Concurrent checks on the top level's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`include "coulomb_force_sum_unit_macros.svh"

module cfsu_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic signed [cfsu_pkg::FRC_W-1:0]    o_force_x,
    input logic signed [cfsu_pkg::FRC_W-1:0]    o_force_y,
    input logic signed [cfsu_pkg::FRC_W-1:0]    o_force_z,
    input logic                                 o_saturated
);

    // A stalled result word stays offered
    `CFSU_CHK_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result word dropped")

    // A stalled result word keeps its payload
    `CFSU_CHK_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_force_x) && $stable(o_force_y) && $stable(o_force_z) && $stable(o_saturated), "stalled result changed")

    // One word in work at a time: no accept right after an accept
    `CFSU_CHK_NEXT(a_in_busy, i_in_valid && o_in_ready, !o_in_ready, "input taken while busy")

    // A result never appears the cycle right after an input accept
    `CFSU_CHK_SAME(a_out_latency, $rose(o_out_valid), !$past(i_in_valid && o_in_ready), "result too early")

endmodule

bind coulomb_force_sum_unit cfsu_checker u_cfsu_checker (.*);
